// ===== src/amrc_pkg.sv =====
package amrc_pkg;

   // Audio lengths and ramp positions are counted in jiffies
   localparam int unsigned JIFFY_W = 28;

   // Front queue depth; pointer and count widths follow from it
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam logic CSR_RAMP_LENGTH  = 1'b0;
   localparam logic CSR_BUFFER_DELAY = 1'b1;

   typedef logic [JIFFY_W-1:0] jiffy_type;

   // Request codes as carried on the func field
   typedef enum logic [2:0] {
      OP_MUTE    = 3'd0,
      OP_UNMUTE  = 3'd1,
      OP_AUDIO   = 3'd2,
      OP_SILENCE = 3'd3,
      OP_HALT    = 3'd4,
      OP_DRAIN   = 3'd5,
      OP_HALTED  = 3'd6,
      OP_DRAINED = 3'd7
   } op_type;

   // Mode codes as reported on mode_now
   localparam logic [2:0] MODE_RUNNING   = 3'd0;
   localparam logic [2:0] MODE_RAMP_DOWN = 3'd1;
   localparam logic [2:0] MODE_MUTING    = 3'd2;
   localparam logic [2:0] MODE_MUTED     = 3'd3;
   localparam logic [2:0] MODE_RAMP_UP   = 3'd4;

   // One queued word after classification
   typedef struct packed {
      op_type    op;
      logic      is_audio;
      logic      is_stop;
      jiffy_type len;
   } item_type;

   // Configuration seen by the back end
   typedef struct packed {
      jiffy_type ramp_length;
      jiffy_type buffer_delay;
   } cfg_type;

   // One result word
   typedef struct packed {
      jiffy_type  segment_jiffies;
      logic       ramping;
      logic       ramp_down;
      jiffy_type  ramp_left;
      logic       audio_muted;
      logic       caller_waits;
      logic       mute_done;
      logic       bad_request;
      logic       halt_ignored;
      logic [2:0] mode_now;
      logic       last;
   } result_type;

endpackage

// ===== src/amrc_front.sv =====
module amrc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_func,
   input  amrc_pkg::jiffy_type   req_chunk_jiffies,
   output logic                  q_valid,
   output amrc_pkg::item_type    q_item,
   input  logic                  q_pop
);

   amrc_pkg::item_type               slot_ff [amrc_pkg::QUEUE_DEPTH];
   logic [amrc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [amrc_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [amrc_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             push;
   logic                             pop;
   amrc_pkg::item_type               word;

   function automatic logic [amrc_pkg::QPTR_W-1:0] ptr_next(
      input logic [amrc_pkg::QPTR_W-1:0] p);
      if (p == amrc_pkg::QPTR_W'(amrc_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Classify the incoming word
   always_comb begin
      word.op       = amrc_pkg::op_type'(req_func);
      word.is_audio = (word.op == amrc_pkg::OP_AUDIO);
      word.is_stop  = (word.op == amrc_pkg::OP_HALTED) || (word.op == amrc_pkg::OP_DRAINED);
      word.len      = req_chunk_jiffies;
   end

   // Stall only when every slot holds a word
   assign req_stall = (count_ff == amrc_pkg::QCNT_W'(amrc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word in its slot
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== src/amrc_back.sv =====
module amrc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  amrc_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  amrc_pkg::item_type    q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output amrc_pkg::result_type  rsp_word
);

   typedef enum logic [2:0] {
      RUNNING   = amrc_pkg::MODE_RUNNING,
      RAMP_DOWN = amrc_pkg::MODE_RAMP_DOWN,
      MUTING    = amrc_pkg::MODE_MUTING,
      MUTED     = amrc_pkg::MODE_MUTED,
      RAMP_UP   = amrc_pkg::MODE_RAMP_UP
   } mode_type;

   mode_type              mode_ff, mode_in;
   amrc_pkg::jiffy_type   ramp_rem_ff, ramp_rem_in;
   amrc_pkg::jiffy_type   countdown_ff, countdown_in;
   logic                  halting_ff, halting_in;
   logic                  halted_ff, halted_in;
   logic                  halt_pend_ff, halt_pend_in;
   logic                  drain_pend_ff, drain_pend_in;
   logic                  split_ff, split_in;
   amrc_pkg::jiffy_type   rest_ff, rest_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   amrc_pkg::result_type  rsp_ff, rsp_in;

   logic                  out_free;
   logic                  fire;
   logic                  do_plain;
   amrc_pkg::jiffy_type   plain_len;
   logic                  finish;
   amrc_pkg::jiffy_type   len;
   amrc_pkg::result_type  res;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign len       = q_item.len;

   // Carry out one word per free output slot
   always_comb begin
      mode_in       = mode_ff;
      ramp_rem_in   = ramp_rem_ff;
      countdown_in  = countdown_ff;
      halting_in    = halting_ff;
      halted_in     = halted_ff;
      halt_pend_in  = halt_pend_ff;
      drain_pend_in = drain_pend_ff;
      split_in      = split_ff;
      rest_in       = rest_ff;
      res           = '0;
      res.last      = 1'b1;
      fire          = 1'b0;
      q_pop         = 1'b0;
      do_plain      = 1'b0;
      plain_len     = len;
      finish        = 1'b0;

      if (out_free && split_ff) begin
         // Second segment of a split chunk, in the mode the ramp left behind
         fire      = 1'b1;
         split_in  = 1'b0;
         do_plain  = 1'b1;
         plain_len = rest_ff;
      end else if (out_free && q_valid) begin
         fire  = 1'b1;
         q_pop = 1'b1;
         case (q_item.op)
            amrc_pkg::OP_MUTE: begin
               if (mode_ff == RUNNING) begin
                  if (halted_ff) begin
                     mode_in = MUTED;
                  end else if (halting_ff) begin
                     mode_in          = MUTING;
                     res.caller_waits = 1'b1;
                  end else begin
                     mode_in          = RAMP_DOWN;
                     ramp_rem_in      = cfg.ramp_length;
                     res.caller_waits = 1'b1;
                  end
               end else if (mode_ff == RAMP_UP) begin
                  if (ramp_rem_ff == cfg.ramp_length) begin
                     mode_in = MUTED;
                  end else begin
                     mode_in          = RAMP_DOWN;
                     ramp_rem_in      = cfg.ramp_length - ramp_rem_ff;
                     res.caller_waits = 1'b1;
                  end
               end else begin
                  res.bad_request = 1'b1;
               end
            end
            amrc_pkg::OP_UNMUTE: begin
               if (mode_ff == RAMP_DOWN) begin
                  res.mute_done = 1'b1;
                  if (ramp_rem_ff == cfg.ramp_length) begin
                     mode_in = RUNNING;
                  end else begin
                     mode_in     = RAMP_UP;
                     ramp_rem_in = cfg.ramp_length - ramp_rem_ff;
                  end
               end else if (mode_ff == MUTING) begin
                  res.mute_done = 1'b1;
                  halting_in    = 1'b0;
                  mode_in       = RAMP_UP;
                  ramp_rem_in   = cfg.ramp_length;
               end else if (mode_ff == MUTED) begin
                  if (halted_ff) begin
                     mode_in = RUNNING;
                  end else begin
                     mode_in     = RAMP_UP;
                     ramp_rem_in = cfg.ramp_length;
                  end
               end else begin
                  res.bad_request = 1'b1;
               end
            end
            amrc_pkg::OP_AUDIO: begin
               if (mode_ff != RAMP_DOWN && mode_ff != RAMP_UP) begin
                  do_plain = 1'b1;
               end else begin
                  halting_in = 1'b0;
                  halted_in  = 1'b0;
                  if (ramp_rem_ff == '0) begin
                     // Ramp already spent: pass the chunk and settle the mode
                     finish              = 1'b1;
                     res.segment_jiffies = len;
                  end else if (len > ramp_rem_ff) begin
                     // Split: ramped head now, plain remainder once the output slot is free
                     ramp_rem_in         = '0;
                     finish              = 1'b1;
                     res.segment_jiffies = ramp_rem_ff;
                     res.ramping         = 1'b1;
                     res.ramp_down       = (mode_ff == RAMP_DOWN);
                     res.ramp_left       = ramp_rem_ff;
                     res.last            = 1'b0;
                     split_in            = 1'b1;
                     rest_in             = len - ramp_rem_ff;
                  end else begin
                     ramp_rem_in         = ramp_rem_ff - len;
                     finish              = (len == ramp_rem_ff);
                     res.segment_jiffies = len;
                     res.ramping         = 1'b1;
                     res.ramp_down       = (mode_ff == RAMP_DOWN);
                     res.ramp_left       = ramp_rem_ff;
                  end
               end
            end
            amrc_pkg::OP_SILENCE: begin
               if (mode_ff == RAMP_DOWN) begin
                  mode_in     = MUTING;
                  ramp_rem_in = '0;
               end else if (mode_ff == RAMP_UP) begin
                  mode_in     = RUNNING;
                  ramp_rem_in = '0;
               end
            end
            amrc_pkg::OP_HALT, amrc_pkg::OP_DRAIN: begin
               if (q_item.op == amrc_pkg::OP_HALT && halt_pend_ff) begin
                  res.halt_ignored = 1'b1;
               end else begin
                  if (q_item.op == amrc_pkg::OP_HALT) begin
                     halt_pend_in = 1'b1;
                  end else begin
                     drain_pend_in = 1'b1;
                  end
                  halting_in = 1'b1;
                  if (mode_ff == RAMP_DOWN) begin
                     mode_in     = MUTING;
                     ramp_rem_in = '0;
                  end
               end
            end
            default: begin
               // Halted or drained notice: downstream has stopped
               if (halting_ff) begin
                  halted_in = 1'b1;
               end
               countdown_in  = '0;
               res.mute_done = 1'b1;
               if (mode_ff == MUTING) begin
                  mode_in = MUTED;
               end
               if (q_item.op == amrc_pkg::OP_HALTED) begin
                  halt_pend_in = 1'b0;
               end else begin
                  drain_pend_in = 1'b0;
               end
            end
         endcase
      end

      // End of a ramp: up returns to running, down starts the buffer countdown
      if (finish) begin
         if (mode_ff == RAMP_UP) begin
            mode_in = RUNNING;
         end else begin
            mode_in      = MUTING;
            countdown_in = cfg.buffer_delay;
         end
      end

      // Unramped audio segment
      if (do_plain) begin
         halting_in          = 1'b0;
         halted_in           = 1'b0;
         res.segment_jiffies = plain_len;
         res.last            = 1'b1;
         if (mode_ff == MUTING) begin
            res.audio_muted = 1'b1;
            if (countdown_ff == '0) begin
               mode_in       = MUTED;
               res.mute_done = 1'b1;
            end else begin
               countdown_in = countdown_ff -
                              ((plain_len < countdown_ff) ? plain_len : countdown_ff);
            end
         end else if (mode_ff == MUTED) begin
            res.audio_muted = 1'b1;
         end
      end

      res.mode_now = mode_in;

      // Load the output register, or drop the word once taken
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= RUNNING;
         ramp_rem_ff   <= '0;
         countdown_ff  <= '0;
         halting_ff    <= 1'b0;
         halted_ff     <= 1'b1;
         halt_pend_ff  <= 1'b0;
         drain_pend_ff <= 1'b0;
         split_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         ramp_rem_ff   <= ramp_rem_in;
         countdown_ff  <= countdown_in;
         halting_ff    <= halting_in;
         halted_ff     <= halted_in;
         halt_pend_ff  <= halt_pend_in;
         drain_pend_ff <= drain_pend_in;
         split_ff      <= split_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rest_ff <= rest_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== src/audio_mute_ramp_controller.sv =====
// An accepted word is registered in its queue slot, then in the result register.
// Throughput: one request word per cycle while no stall or split holds it; an audio
// chunk split at a ramp's end gives two result words via the single result register.
// The two-entry front queue takes new words while a result waits on rsp_stall.
// Reset: mode running, ramp and countdown zero, halted set, queue and results empty,
// ramp_length and buffer_delay zero.
module audio_mute_ramp_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  amrc_pkg::jiffy_type req_chunk_jiffies,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output amrc_pkg::jiffy_type rsp_segment_jiffies,
   output logic                rsp_ramping,
   output logic                rsp_ramp_down,
   output amrc_pkg::jiffy_type rsp_ramp_left,
   output logic                rsp_audio_muted,
   output logic                rsp_caller_waits,
   output logic                rsp_mute_done,
   output logic                rsp_bad_request,
   output logic                rsp_halt_ignored,
   output logic [2:0]          rsp_mode_now,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  amrc_pkg::jiffy_type csr_data
);

   amrc_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  q_valid;
   amrc_pkg::item_type    q_item;
   logic                  q_pop;
   amrc_pkg::result_type  rsp_word;

   // Take configuration writes at any time
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            amrc_pkg::CSR_RAMP_LENGTH:  cfg_in.ramp_length  = csr_data;
            amrc_pkg::CSR_BUFFER_DELAY: cfg_in.buffer_delay = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amrc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_chunk_jiffies (req_chunk_jiffies),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   amrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Unpack the result word onto its ports
   assign rsp_segment_jiffies = rsp_word.segment_jiffies;
   assign rsp_ramping         = rsp_word.ramping;
   assign rsp_ramp_down       = rsp_word.ramp_down;
   assign rsp_ramp_left       = rsp_word.ramp_left;
   assign rsp_audio_muted     = rsp_word.audio_muted;
   assign rsp_caller_waits    = rsp_word.caller_waits;
   assign rsp_mute_done       = rsp_word.mute_done;
   assign rsp_bad_request     = rsp_word.bad_request;
   assign rsp_halt_ignored    = rsp_word.halt_ignored;
   assign rsp_mode_now        = rsp_word.mode_now;
   assign rsp_last            = rsp_word.last;

endmodule

// ===== src/amrc_checker.sv =====
module amrc_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input amrc_pkg::jiffy_type rsp_segment_jiffies,
   input logic                rsp_ramping,
   input logic                rsp_ramp_down,
   input amrc_pkg::jiffy_type rsp_ramp_left,
   input logic                rsp_audio_muted,
   input logic                rsp_last
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segment_jiffies)
                                 && $stable(rsp_last))
      else $error("result word changed while stalled");

   // An unramped segment carries no ramp position
   a_no_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ramping |-> !rsp_ramp_down && rsp_ramp_left == '0)
      else $error("ramp fields set on unramped segment");

   // A ramped segment fits within the ramp that remains
   a_ramp_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ramping |-> rsp_ramp_left != '0
                                   && rsp_segment_jiffies <= rsp_ramp_left)
      else $error("ramped segment longer than ramp left");

   // Only the ramped head of a split chunk is followed by more results
   a_split_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_ramping && !rsp_audio_muted)
      else $error("non-final result is not a ramped head");

endmodule

bind audio_mute_ramp_controller amrc_checker u_amrc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_segment_jiffies (rsp_segment_jiffies),
   .rsp_ramping         (rsp_ramping),
   .rsp_ramp_down       (rsp_ramp_down),
   .rsp_ramp_left       (rsp_ramp_left),
   .rsp_audio_muted     (rsp_audio_muted),
   .rsp_last            (rsp_last)
);
